// File: sv/sminv_pkg.sv
// Shared types and fixed constants for the small matrix inverse block.
// No dependencies; imported by the top level and by its port checker.
package sminv_pkg;

    localparam int ELEM_W  = 16;
    localparam int INV_W   = 32;
    localparam int DET_W   = 48;
    localparam int DIM_W   = 2;
    localparam int MAX_DIM = 3;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [INV_W-1:0]  inv_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [DIM_W-1:0]         dim_t;

    localparam dim_t DIM_RESET = dim_t'(3);
    localparam inv_t INV_MAX   = 32'sh7FFF_FFFF;
    localparam inv_t INV_MIN   = 32'sh8000_0000;
    localparam logic signed [63:0] DET_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] DET_MIN = -64'sh0000_8000_0000_0000;

endpackage

// File: sv/small_matrix_inverse.sv
// Small matrix inverse (sizes 1 to 3) by the adjugate: top level and datapath.
// Depends on sminv_pkg.
//
// Accepts one matrix per clock unless back-pressure stalls the pipe, and returns
// its determinant (Q32.16, saturated), a singular flag and the inverse (Q16.16,
// saturated). The pipe runs a nine-lane restoring divider, one quotient bit per
// stage over 32 stages, behind six stages of cofactor and determinant
// arithmetic. A stage holds only while it is full and the one after it holds,
// so bubbles close up under back-pressure. The active size is written through
// the cfg port, which is always ready; write it only while the pipe is empty.
module small_matrix_inverse #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  sminv_pkg::dim_t      cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sminv_pkg::elem_t     s_elem_r0c0,
    input  sminv_pkg::elem_t     s_elem_r0c1,
    input  sminv_pkg::elem_t     s_elem_r0c2,
    input  sminv_pkg::elem_t     s_elem_r1c0,
    input  sminv_pkg::elem_t     s_elem_r1c1,
    input  sminv_pkg::elem_t     s_elem_r1c2,
    input  sminv_pkg::elem_t     s_elem_r2c0,
    input  sminv_pkg::elem_t     s_elem_r2c1,
    input  sminv_pkg::elem_t     s_elem_r2c2,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sminv_pkg::inv_t      m_inv_r0c0,
    output sminv_pkg::inv_t      m_inv_r0c1,
    output sminv_pkg::inv_t      m_inv_r0c2,
    output sminv_pkg::inv_t      m_inv_r1c0,
    output sminv_pkg::inv_t      m_inv_r1c1,
    output sminv_pkg::inv_t      m_inv_r1c2,
    output sminv_pkg::inv_t      m_inv_r2c0,
    output sminv_pkg::inv_t      m_inv_r2c1,
    output sminv_pkg::inv_t      m_inv_r2c2,
    output sminv_pkg::det_t      m_det_value,
    output logic                 m_singular
);
    import sminv_pkg::*;

    localparam int DIV_STAGES = 32;
    localparam int NST        = 6 + DIV_STAGES + 1;
    localparam int NW         = 49 + FRAC_BITS;   // numerator plus half divisor
    localparam int CW         = 81;               // compare width for dm << 32
    localparam int DM_W       = 48;

    typedef struct packed {
        logic [NW-1:0]    rem;
        logic [INV_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } lane_t;

    // ---------------- handshake / valid chain ----------------
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_en
            assign en[k] = ~v_reg[k] | en[k+1];
        end
    endgenerate
    assign en[NST-1] = ~v_reg[NST-1] | m_ready;

    assign v_next  = (en & {v_reg[NST-2:0], s_valid}) | (~en & v_reg);
    assign s_ready = en[0];
    assign m_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // ---------------- configuration ----------------
    dim_t matrix_size_reg;
    dim_t n_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            matrix_size_reg <= cfg_data;
        end
    end

    always_comb begin
        if (matrix_size_reg == dim_t'(0)) begin
            n_eff = dim_t'(1);
        end else if (matrix_size_reg > dim_t'(MAX_DIM)) begin
            n_eff = dim_t'(MAX_DIM);
        end else begin
            n_eff = matrix_size_reg;
        end
    end

    // ---------------- stage 0: capture, pad to 3x3 ----------------
    // Outside the active block the diagonal reads 1 and the rest 0, so the 3x3
    // cofactors inside the active block and the determinant equal those of the active block.
    elem_t in_elem [0:2][0:2];
    elem_t m_reg   [0:2][0:2];
    dim_t  n0_reg;

    assign in_elem[0][0] = s_elem_r0c0;
    assign in_elem[0][1] = s_elem_r0c1;
    assign in_elem[0][2] = s_elem_r0c2;
    assign in_elem[1][0] = s_elem_r1c0;
    assign in_elem[1][1] = s_elem_r1c1;
    assign in_elem[1][2] = s_elem_r1c2;
    assign in_elem[2][0] = s_elem_r2c0;
    assign in_elem[2][1] = s_elem_r2c1;
    assign in_elem[2][2] = s_elem_r2c2;

    genvar r, c;
    generate
        for (r = 0; r < 3; r++) begin : g_s0r
            for (c = 0; c < 3; c++) begin : g_s0c
                always_ff @(posedge aclk) begin
                    if (en[0]) begin
                        if (dim_t'(r) < n_eff && dim_t'(c) < n_eff) begin
                            m_reg[r][c] <= in_elem[r][c];
                        end else if (r == c) begin
                            m_reg[r][c] <= elem_t'(1);
                        end else begin
                            m_reg[r][c] <= '0;
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            n0_reg <= n_eff;
        end
    end

    // ---------------- stage 1: minor products ----------------
    logic signed [31:0] p1_reg [0:2][0:2];
    logic signed [31:0] p2_reg [0:2][0:2];
    elem_t              m0_s1_reg [0:2];
    dim_t               n1_reg;

    generate
        for (r = 0; r < 3; r++) begin : g_s1r
            for (c = 0; c < 3; c++) begin : g_s1c
                localparam int A0 = (r == 0) ? 1 : 0;
                localparam int A1 = (r == 2) ? 1 : 2;
                localparam int B0 = (c == 0) ? 1 : 0;
                localparam int B1 = (c == 2) ? 1 : 2;
                always_ff @(posedge aclk) begin
                    if (en[1]) begin
                        p1_reg[r][c] <= m_reg[A0][B0] * m_reg[A1][B1];
                        p2_reg[r][c] <= m_reg[A0][B1] * m_reg[A1][B0];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            m0_s1_reg <= m_reg[0];
            n1_reg    <= n0_reg;
        end
    end

    // ---------------- stage 2: signed cofactors ----------------
    logic signed [32:0] cof2_reg [0:2][0:2];
    elem_t              m0_s2_reg [0:2];
    dim_t               n2_reg;

    generate
        for (r = 0; r < 3; r++) begin : g_s2r
            for (c = 0; c < 3; c++) begin : g_s2c
                always_ff @(posedge aclk) begin
                    if (en[2]) begin
                        if (((r + c) % 2) == 1) begin
                            cof2_reg[r][c] <= 33'(p2_reg[r][c]) - 33'(p1_reg[r][c]);
                        end else begin
                            cof2_reg[r][c] <= 33'(p1_reg[r][c]) - 33'(p2_reg[r][c]);
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            m0_s2_reg <= m0_s1_reg;
            n2_reg    <= n1_reg;
        end
    end

    // ---------------- stage 3: expansion along row 0 ----------------
    logic signed [48:0] dp_reg   [0:2];
    logic signed [32:0] cof3_reg [0:2][0:2];
    dim_t               n3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                dp_reg[i] <= 49'(m0_s2_reg[i]) * 49'(cof2_reg[0][i]);
            end
            cof3_reg <= cof2_reg;
            n3_reg   <= n2_reg;
        end
    end

    // ---------------- stage 4: determinant ----------------
    logic signed [50:0] det4_reg;
    logic signed [32:0] cof4_reg [0:2][0:2];
    dim_t               n4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            det4_reg <= 51'(dp_reg[0]) + 51'(dp_reg[1]) + 51'(dp_reg[2]);
            cof4_reg <= cof3_reg;
            n4_reg   <= n3_reg;
        end
    end

    // ---------------- stage 5: rescale, numerators, range check ----------------
    lane_t              div_reg  [0:DIV_STAGES][0:8];
    logic [DM_W-1:0]    dm_reg   [0:DIV_STAGES];
    det_t               dq_reg   [0:DIV_STAGES];
    logic               sing_reg [0:DIV_STAGES];
    dim_t               n_reg    [0:DIV_STAGES];

    logic [50:0]        det_abs;
    logic [DM_W-1:0]    dm_next;
    logic signed [63:0] dq_wide;
    logic [63:0]        dq_mag;
    int                 sh;
    det_t               dq_next;
    lane_t              prep_next [0:8];

    always_comb begin
        logic signed [32:0] cv;
        logic [31:0]        cv_abs;
        logic [NW-1:0]      num;
        det_abs = det4_reg[50] ? 51'(-det4_reg) : 51'(det4_reg);
        dm_next = det_abs[DM_W-1:0];
        sh      = int'(n4_reg) * FRAC_BITS - 16;
        dq_mag  = '0;
        if (sh <= 0) begin
            dq_wide = 64'(det4_reg) <<< (-sh);
        end else begin
            dq_mag  = (64'(det_abs) + (64'd1 << (sh - 1))) >> sh;
            dq_wide = det4_reg[50] ? -$signed(dq_mag) : $signed(dq_mag);
        end
        if (dq_wide > DET_MAX) begin
            dq_next = det_t'(DET_MAX);
        end else if (dq_wide < DET_MIN) begin
            dq_next = det_t'(DET_MIN);
        end else begin
            dq_next = dq_wide[DET_W-1:0];
        end
        // inverse (i,j) divides cofactor (j,i)
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cv     = cof4_reg[j][i];
                cv_abs = cv[32] ? 32'(-cv) : 32'(cv);
                num    = NW'(cv_abs) << (FRAC_BITS + 16);
                prep_next[i*3+j].rem = num + NW'(dm_next >> 1);
                prep_next[i*3+j].quo = '0;
                prep_next[i*3+j].neg = cv[32] ^ det4_reg[50];
                prep_next[i*3+j].ovf =
                    CW'(prep_next[i*3+j].rem) >= (CW'(dm_next) << DIV_STAGES);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            div_reg[0]  <= prep_next;
            dm_reg[0]   <= dm_next;
            dq_reg[0]   <= dq_next;
            sing_reg[0] <= (det4_reg == '0);
            n_reg[0]    <= n4_reg;
        end
    end

    // ---------------- stages 6..37: restoring divider, one bit each ----------------
    genvar d, l;
    generate
        for (d = 1; d <= DIV_STAGES; d++) begin : g_div
            localparam int B = DIV_STAGES - d;
            logic [CW-1:0] trial;
            assign trial = CW'(dm_reg[d-1]) << B;
            for (l = 0; l < 9; l++) begin : g_lane
                logic          take;
                lane_t         nxt;
                assign take = CW'(div_reg[d-1][l].rem) >= trial;
                always_comb begin
                    nxt = div_reg[d-1][l];
                    if (take) begin
                        nxt.rem    = NW'(CW'(div_reg[d-1][l].rem) - trial);
                        nxt.quo[B] = 1'b1;
                    end
                end
                always_ff @(posedge aclk) begin
                    if (en[5+d]) begin
                        div_reg[d][l] <= nxt;
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (en[5+d]) begin
                    dm_reg[d]   <= dm_reg[d-1];
                    dq_reg[d]   <= dq_reg[d-1];
                    sing_reg[d] <= sing_reg[d-1];
                    n_reg[d]    <= n_reg[d-1];
                end
            end
        end
    endgenerate

    // ---------------- stage 38: sign, saturation, masking ----------------
    inv_t inv_reg [0:8];
    inv_t inv_next [0:8];
    det_t det_out_reg;
    logic sing_out_reg;

    always_comb begin
        lane_t ln;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ln = div_reg[DIV_STAGES][i*3+j];
                if (sing_reg[DIV_STAGES] || dim_t'(i) >= n_reg[DIV_STAGES]
                        || dim_t'(j) >= n_reg[DIV_STAGES]) begin
                    inv_next[i*3+j] = '0;
                end else if (ln.neg) begin
                    if (ln.ovf || ln.quo > 32'h8000_0000) begin
                        inv_next[i*3+j] = INV_MIN;
                    end else begin
                        inv_next[i*3+j] = inv_t'(-ln.quo);
                    end
                end else if (ln.ovf || ln.quo > 32'h7FFF_FFFF) begin
                    inv_next[i*3+j] = INV_MAX;
                end else begin
                    inv_next[i*3+j] = inv_t'(ln.quo);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            inv_reg      <= inv_next;
            det_out_reg  <= sing_reg[DIV_STAGES] ? '0 : dq_reg[DIV_STAGES];
            sing_out_reg <= sing_reg[DIV_STAGES];
        end
    end

    assign m_inv_r0c0  = inv_reg[0];
    assign m_inv_r0c1  = inv_reg[1];
    assign m_inv_r0c2  = inv_reg[2];
    assign m_inv_r1c0  = inv_reg[3];
    assign m_inv_r1c1  = inv_reg[4];
    assign m_inv_r1c2  = inv_reg[5];
    assign m_inv_r2c0  = inv_reg[6];
    assign m_inv_r2c1  = inv_reg[7];
    assign m_inv_r2c2  = inv_reg[8];
    assign m_det_value = det_out_reg;
    assign m_singular  = sing_out_reg;

endmodule

// File: sv/sminv_checker.sv
// Port-level checks for small_matrix_inverse, attached by the bind below.
// Depends on sminv_pkg and the top level's ports.
module sminv_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_singular,
    input sminv_pkg::det_t  m_det_value,
    input sminv_pkg::inv_t  m_inv_r0c0,
    input sminv_pkg::inv_t  m_inv_r1c1,
    input sminv_pkg::inv_t  m_inv_r2c2
);
    import sminv_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_det_value) && $stable(m_inv_r0c0))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_sing_det: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_det_value == '0)
        else $error("singular beat with nonzero determinant");

    a_sing_inv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_inv_r0c0 == '0 && m_inv_r1c1 == '0
            && m_inv_r2c2 == '0)
        else $error("singular beat with nonzero inverse");

endmodule

bind small_matrix_inverse sminv_checker u_sminv_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_singular  (m_singular),
    .m_det_value (m_det_value),
    .m_inv_r0c0  (m_inv_r0c0),
    .m_inv_r1c1  (m_inv_r1c1),
    .m_inv_r2c2  (m_inv_r2c2)
);
